// File: hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, operation and status codes, the command struct passed
// from the front to the back part of the queue unit, and the status struct.
// ----------------------------------------------------------------------------
package dq_pkg;

	// Queue sizing. DATA_WIDTH matches the 32-bit value and item fields.
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// Input operation codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_LIST       = 3'd4;

	// Classified command kinds
	localparam logic [2:0] CMD_NOP        = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_POP_BACK   = 3'd4;
	localparam logic [2:0] CMD_LIST       = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd2;
	localparam logic [1:0] ST_LIST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]            kind;
		logic [DATA_WIDTH-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic             listing;
	} stat_t;

	// Ring position of the entry at offset off from base (off < DEPTH)
	function automatic logic [IDX_W-1:0] ring_pos(logic [IDX_W-1:0] base,
	                                              logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// File: hw/rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Accepts input items, classifies the operation into a command kind and
// holds commands in a short queue until the back part takes them.
// ----------------------------------------------------------------------------
module dq_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           op,
	input  logic signed [dq_pkg::DATA_WIDTH-1:0] value,
	output logic                                 cmd_valid,
	output dq_pkg::cmd_t                         cmd,
	input  logic                                 cmd_pop
);

	dq_pkg::cmd_t                  slot_q [dq_pkg::CQ_DEPTH];
	logic [dq_pkg::CQ_PTR_W-1:0]   wr_ptr_q;
	logic [dq_pkg::CQ_PTR_W-1:0]   rd_ptr_q;
	logic [dq_pkg::CQ_CNT_W-1:0]   cnt_q;
	logic [2:0]                    kind;
	logic                          push;

	// Classify the operation; unused codes become a no-op
	always_comb begin
		unique case (op)
			dq_pkg::OP_PUSH_FRONT: kind = dq_pkg::CMD_PUSH_FRONT;
			dq_pkg::OP_PUSH_BACK:  kind = dq_pkg::CMD_PUSH_BACK;
			dq_pkg::OP_POP_FRONT:  kind = dq_pkg::CMD_POP_FRONT;
			dq_pkg::OP_POP_BACK:   kind = dq_pkg::CMD_POP_BACK;
			dq_pkg::OP_LIST:       kind = dq_pkg::CMD_LIST;
			default:               kind = dq_pkg::CMD_NOP;
		endcase
	end

	assign in_stall  = (cnt_q == dq_pkg::CQ_CNT_W'(dq_pkg::CQ_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	// Store classified commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{kind: kind, value: value};
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dq_pkg::CQ_PTR_W'(dq_pkg::CQ_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == dq_pkg::CQ_PTR_W'(dq_pkg::CQ_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Carries out queue commands on the ring buffer: updates head and fill
// count, writes pushed values, walks the entries for a listing, and drives
// the registered result port.
// ----------------------------------------------------------------------------
module dq_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  dq_pkg::cmd_t                         cmd,
	output logic                                 cmd_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dq_pkg::DATA_WIDTH-1:0] item,
	output logic [1:0]                           status,
	output logic                                 last,
	output dq_pkg::stat_t                        stat
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SEND = 1'b1;

	logic                          state_q, state_d;
	logic [dq_pkg::IDX_W-1:0]      front_q, front_d;
	logic [dq_pkg::CNT_W-1:0]      fill_q, fill_d;
	logic [dq_pkg::CNT_W-1:0]      idx_q, idx_d;
	logic                          out_valid_q;
	logic [dq_pkg::DATA_WIDTH-1:0] item_q;
	logic [1:0]                    status_q;
	logic                          last_q;

	logic                          out_free;
	logic                          full;
	logic                          empty;
	logic                          list_last;
	logic [dq_pkg::IDX_W-1:0]      front_dec;
	logic [dq_pkg::CNT_W-1:0]      idx_nxt;
	logic                          load;
	logic [dq_pkg::DATA_WIDTH-1:0] load_item;
	logic [1:0]                    load_status;
	logic                          load_last;
	logic                          wr_en;
	logic [dq_pkg::IDX_W-1:0]      wr_addr;
	logic                          rd_en;
	logic [dq_pkg::IDX_W-1:0]      rd_addr;
	logic [dq_pkg::DATA_WIDTH-1:0] rd_data;

	dq_ram #(
		.WIDTH (dq_pkg::DATA_WIDTH),
		.DEPTH (dq_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (fill_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty     = (fill_q == '0);
	assign idx_nxt   = idx_q + 1'b1;
	assign list_last = (idx_nxt == fill_q);
	assign front_dec = (front_q == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) :
	                   front_q - 1'b1;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && out_free;

	// Execute one command, or send the next listed entry
	always_comb begin
		state_d     = state_q;
		front_d     = front_q;
		fill_d      = fill_q;
		idx_d       = idx_q;
		wr_en       = 1'b0;
		wr_addr     = front_q;
		rd_en       = 1'b0;
		rd_addr     = front_q;
		load        = 1'b0;
		load_item   = '0;
		load_status = dq_pkg::ST_OK;
		load_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					load = 1'b1;
					unique case (cmd.kind)
						dq_pkg::CMD_PUSH_FRONT: begin
							if (full) begin
								load_status = dq_pkg::ST_PUSH_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = front_dec;
								front_d = front_dec;
								fill_d  = fill_q + 1'b1;
							end
						end
						dq_pkg::CMD_PUSH_BACK: begin
							if (full) begin
								load_status = dq_pkg::ST_PUSH_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = dq_pkg::ring_pos(front_q, fill_q);
								fill_d  = fill_q + 1'b1;
							end
						end
						dq_pkg::CMD_POP_FRONT: begin
							if (empty) begin
								load_status = dq_pkg::ST_POP_EMPTY;
							end else begin
								front_d = dq_pkg::ring_pos(front_q, dq_pkg::CNT_W'(1));
								fill_d  = fill_q - 1'b1;
							end
						end
						dq_pkg::CMD_POP_BACK: begin
							if (empty) begin
								load_status = dq_pkg::ST_POP_EMPTY;
							end else begin
								fill_d = fill_q - 1'b1;
							end
						end
						dq_pkg::CMD_LIST: begin
							if (empty) begin
								load_status = dq_pkg::ST_LIST_EMPTY;
							end else begin
								// fetch the front entry, results follow from S_SEND
								load    = 1'b0;
								rd_en   = 1'b1;
								rd_addr = front_q;
								idx_d   = '0;
								state_d = S_SEND;
							end
						end
						default: begin
							load_status = dq_pkg::ST_OK;
						end
					endcase
				end
			end
			S_SEND: begin
				if (out_free) begin
					load      = 1'b1;
					load_item = rd_data;
					load_last = list_last;
					if (list_last) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = dq_pkg::ring_pos(front_q, idx_nxt);
						idx_d   = idx_nxt;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, held while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			item_q   <= load_item;
			status_q <= load_status;
			last_q   <= load_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign item         = item_q;
	assign status       = status_q;
	assign last         = last_q;
	assign stat.fill    = fill_q;
	assign stat.listing = (state_q == S_SEND);

endmodule

// File: hw/rtl/double_ended_queue_unit.sv
// A push, pop or unknown op is queued in the front part, then its result is registered.
// Throughput: one push, pop or unknown op per cycle unless a listing or out_stall holds it.
// A listing primes with one RAM read, then sends one entry a cycle while out_stall is low.
// While a listing runs, up to two further items wait in the command queue.
// Reset (arst_n low) empties the queue and zeroes the head; stored values are not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values on a ring buffer,
// with push and pop at both ends and a front-to-back listing.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           op,
	input  logic signed [dq_pkg::DATA_WIDTH-1:0] value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dq_pkg::DATA_WIDTH-1:0] item,
	output logic [1:0]                           status,
	output logic                                 last
);

	logic          cmd_valid;
	dq_pkg::cmd_t  cmd;
	logic          cmd_pop;
	dq_pkg::stat_t stat;

	// Accept and classify items
	dq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Execute commands on the ring buffer
	dq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.item      (item),
		.status    (status),
		.last      (last),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	// Fill count never exceeds the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("fill count above queue depth");

	// No new command is taken while a listing is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.listing |-> !cmd_pop)
		else $error("command taken during listing");

	// Fill count moves by at most one per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(stat.fill == $past(stat.fill)) ||
		(stat.fill == $past(stat.fill) + 1'b1) ||
		(stat.fill == $past(stat.fill) - 1'b1))
		else $error("fill count jumped");

	// Fill count holds while a listing runs
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.listing |=> $stable(stat.fill))
		else $error("fill count changed during listing");
`endif

endmodule
